// ===== design/q2aa_pkg.sv =====
// ----------------------------------------------------------------------------
// q2aa_pkg: shared types and constants for the quaternion to axis-angle block
// Holds the beat structs, the pipeline carry structs and the CORDIC
// arctangent table.
// ----------------------------------------------------------------------------
package q2aa_pkg;

    localparam int FRAC_BITS  = 14;
    localparam int ROOT_BITS  = FRAC_BITS + 1;          // sqrt result bits
    localparam int QUO_BITS   = FRAC_BITS + 1;          // quotient bits
    localparam int REM_BITS   = 2 * FRAC_BITS + 3;      // sqrt / divide remainder
    localparam int CW         = 34;                     // CORDIC datapath width
    localparam int CSHIFT     = 30 - FRAC_BITS;         // Q.FRAC to Q.30
    localparam logic [15:0] ONE_Q     = 16'(1 << FRAC_BITS);
    localparam logic [17:0] ANGLE_MAX = 18'd51472;
    localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;

    typedef struct packed {
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
    } t_quat;

    typedef struct packed {
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic signed [15:0] axis_z;
        logic [15:0]        rot_angle;
        logic               degenerate;
    } t_result;

    // fields that ride along every cell
    typedef struct packed {
        logic signed [15:0] w;
        logic signed [15:0] qx;
        logic signed [15:0] qy;
        logic signed [15:0] qz;
        logic               deg;
    } t_carry;

    typedef struct packed {
        logic [REM_BITS-1:0]  rem;
        logic [ROOT_BITS-1:0] root;
    } t_sqrt;

    typedef struct packed {
        logic [ROOT_BITS-1:0]            s;
        logic [2:0][REM_BITS-1:0]        rem;
        logic [2:0][QUO_BITS-1:0]        q;
        logic [2:0]                      big;
        logic [2:0]                      neg;
    } t_div;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic [2:0][15:0]     axis;
    } t_cordic;

    // round(atan(2^-i) * 2^30)
    function automatic logic signed [CW-1:0] atan_q30(input int i);
        logic signed [CW-1:0] v;
        v = '0;
        case (i)
            0: v = 34'sd843314857;
            1: v = 34'sd497837829;
            2: v = 34'sd263043837;
            3: v = 34'sd133525159;
            4: v = 34'sd67021687;
            5: v = 34'sd33543516;
            6: v = 34'sd16775851;
            7: v = 34'sd8388437;
            8: v = 34'sd4194283;
            9: v = 34'sd2097149;
            default: begin
                if (i <= 30) v = 34'sd1 <<< (30 - i);
                else         v = '0;
            end
        endcase
        return v;
    endfunction

endpackage

// ===== design/q2aa_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// q2aa_sqrt_cell: one root bit of the pipelined integer square root
// Tries bit B of the root against the running remainder.
// ----------------------------------------------------------------------------
module q2aa_sqrt_cell
    import q2aa_pkg::*;
#(
    parameter int B = 0
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_vld,
    input  t_carry i_carry,
    input  t_sqrt  i_sq,
    output logic   o_vld,
    output t_carry o_carry,
    output t_sqrt  o_sq
);

    logic          r_vld;
    t_carry        r_carry;
    t_sqrt         r_sq, n_sq;
    logic [REM_BITS:0] cost;

    always_comb begin
        // (root + 2^B)^2 - root^2
        cost = ((REM_BITS+1)'(i_sq.root) << (B + 1)) + ((REM_BITS+1)'(1) << (2 * B));
        n_sq = i_sq;
        if ({1'b0, i_sq.rem} >= cost) begin
            n_sq.rem  = REM_BITS'({1'b0, i_sq.rem} - cost);
            n_sq.root = i_sq.root | (ROOT_BITS'(1) << B);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= 1'b0;
        else          r_vld <= i_vld;
        r_carry <= i_carry;
        r_sq    <= n_sq;
    end

    assign o_vld   = r_vld;
    assign o_carry = r_carry;
    assign o_sq    = r_sq;

endmodule

// ===== design/q2aa_div_cell.sv =====
// ----------------------------------------------------------------------------
// q2aa_div_cell: one quotient bit for the three axis dividers
// Subtracts s shifted by B where the remainder allows.
// ----------------------------------------------------------------------------
module q2aa_div_cell
    import q2aa_pkg::*;
#(
    parameter int B = 0
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_vld,
    input  t_carry i_carry,
    input  t_div   i_dv,
    output logic   o_vld,
    output t_carry o_carry,
    output t_div   o_dv
);

    logic                r_vld;
    t_carry              r_carry;
    t_div                r_dv, n_dv;
    logic [REM_BITS-1:0] sub;

    always_comb begin
        sub  = REM_BITS'(i_dv.s) << B;
        n_dv = i_dv;
        for (int l = 0; l < 3; l++) begin
            if (i_dv.rem[l] >= sub) begin
                n_dv.rem[l] = i_dv.rem[l] - sub;
                n_dv.q[l]   = i_dv.q[l] | (QUO_BITS'(1) << B);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= 1'b0;
        else          r_vld <= i_vld;
        r_carry <= i_carry;
        r_dv    <= n_dv;
    end

    assign o_vld   = r_vld;
    assign o_carry = r_carry;
    assign o_dv    = r_dv;

endmodule

// ===== design/q2aa_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// q2aa_cordic_cell: one vectoring-mode CORDIC rotation
// Drives y toward zero and accumulates the angle in z.
// ----------------------------------------------------------------------------
module q2aa_cordic_cell
    import q2aa_pkg::*;
#(
    parameter int I = 0
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_vld,
    input  t_carry  i_carry,
    input  t_cordic i_cr,
    output logic    o_vld,
    output t_carry  o_carry,
    output t_cordic o_cr
);

    localparam logic signed [CW-1:0] ATAN = atan_q30(I);

    logic    r_vld;
    t_carry  r_carry;
    t_cordic r_cr, n_cr;

    always_comb begin
        n_cr = i_cr;
        if (i_cr.y >= 0) begin
            n_cr.x = i_cr.x + (i_cr.y >>> I);
            n_cr.y = i_cr.y - (i_cr.x >>> I);
            n_cr.z = i_cr.z + ATAN;
        end else begin
            n_cr.x = i_cr.x - (i_cr.y >>> I);
            n_cr.y = i_cr.y + (i_cr.x >>> I);
            n_cr.z = i_cr.z - ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= 1'b0;
        else          r_vld <= i_vld;
        r_carry <= i_carry;
        r_cr    <= n_cr;
    end

    assign o_vld   = r_vld;
    assign o_carry = r_carry;
    assign o_cr    = r_cr;

endmodule

// ===== design/quaternion_to_axis_angle.sv =====
// ----------------------------------------------------------------------------
// quaternion_to_axis_angle: unit quaternion to rotation axis and angle
// Pipelined chain of square-root, divider and CORDIC cells.
// ----------------------------------------------------------------------------
// Usage:
//   Present a quaternion beat on i_quat (Q1.14 w, x, y, z) with start high.
//   busy is always low, so a beat is taken at every edge where start is high.
//   One result beat appears on o_result with o_done high for one cycle
//   for each input beat, in the order the beats were taken.
//   Throughput is one beat per cycle: every cell is one register stage and
//   all beats move through the chain in lockstep.
//   The chain: one input stage (w*w), 15 root cells, one divider setup
//   stage, 15 quotient cells, one CORDIC setup stage, CORDIC_STAGES
//   rotation cells and one output stage. The divider and root chain
//   lengths follow from the 15-bit root of a Q1.14 value.
//   |w| >= 1 raises degenerate, zeroes the axis and clamps the angle.
//   Reset clears the valid flags of every stage; beats in flight are dropped.
//   The receiver cannot stall: it must take each result in its cycle.
// ----------------------------------------------------------------------------
module quaternion_to_axis_angle
    import q2aa_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_quat   i_quat,
    output logic    o_done,
    output t_result o_result
);

    // ---- input stage: form 1 - w^2 and flag the degenerate scalar
    logic   r_v0;
    t_carry r_c0, n_c0;
    t_sqrt  r_s0, n_s0;
    logic signed [31:0] wsq;

    assign busy = 1'b0;

    always_comb begin
        wsq        = i_quat.quat_w * i_quat.quat_w;
        n_c0.w     = i_quat.quat_w;
        n_c0.qx    = i_quat.quat_x;
        n_c0.qy    = i_quat.quat_y;
        n_c0.qz    = i_quat.quat_z;
        n_c0.deg   = (i_quat.quat_w >= $signed(ONE_Q)) || (i_quat.quat_w <= -$signed(ONE_Q));
        n_s0.root  = '0;
        // hold the remainder at zero for a degenerate scalar
        n_s0.rem   = n_c0.deg ? '0
                   : REM_BITS'((REM_BITS'(1) << (2 * FRAC_BITS)) - REM_BITS'(wsq));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v0 <= 1'b0;
        else          r_v0 <= start && !busy;
        r_c0 <= n_c0;
        r_s0 <= n_s0;
    end

    // ---- square root chain, one root bit per cell
    logic   sq_v [0:ROOT_BITS];
    t_carry sq_c [0:ROOT_BITS];
    t_sqrt  sq_d [0:ROOT_BITS];

    assign sq_v[0] = r_v0;
    assign sq_c[0] = r_c0;
    assign sq_d[0] = r_s0;

    for (genvar k = 0; k < ROOT_BITS; k++) begin : g_sqrt
        q2aa_sqrt_cell #(.B(ROOT_BITS - 1 - k)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (sq_v[k]),
            .i_carry (sq_c[k]),
            .i_sq    (sq_d[k]),
            .o_vld   (sq_v[k+1]),
            .o_carry (sq_c[k+1]),
            .o_sq    (sq_d[k+1])
        );
    end

    // ---- divider setup: numerators with rounding bias, overflow check
    logic   r_v1;
    t_carry r_c1;
    t_div   r_d1, n_d1;
    logic [ROOT_BITS-1:0]        s_fix;
    logic signed [2:0][15:0]     lane_in;
    logic signed [16:0]          ve;
    logic [16:0]                 mag;
    logic [REM_BITS-1:0]         num;

    always_comb begin
        s_fix      = (sq_d[ROOT_BITS].root == '0) ? ROOT_BITS'(1) : sq_d[ROOT_BITS].root;
        lane_in[0] = sq_c[ROOT_BITS].qx;
        lane_in[1] = sq_c[ROOT_BITS].qy;
        lane_in[2] = sq_c[ROOT_BITS].qz;
        n_d1       = '0;
        n_d1.s     = s_fix;
        ve         = '0;
        mag        = '0;
        num        = '0;
        for (int l = 0; l < 3; l++) begin
            // a lane select is unsigned; sign-extend it explicitly
            ve  = 17'($signed(lane_in[l]));
            mag = (ve < 0) ? 17'(-ve) : 17'(ve);
            num = (REM_BITS'(mag) << FRAC_BITS) + REM_BITS'(s_fix >> 1);
            n_d1.rem[l] = num;
            n_d1.big[l] = num >= (REM_BITS'(s_fix) << QUO_BITS);
            n_d1.neg[l] = lane_in[l][15];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else          r_v1 <= sq_v[ROOT_BITS];
        r_c1 <= sq_c[ROOT_BITS];
        r_d1 <= n_d1;
    end

    // ---- divider chain, one quotient bit per cell
    logic   dv_v [0:QUO_BITS];
    t_carry dv_c [0:QUO_BITS];
    t_div   dv_d [0:QUO_BITS];

    assign dv_v[0] = r_v1;
    assign dv_c[0] = r_c1;
    assign dv_d[0] = r_d1;

    for (genvar k = 0; k < QUO_BITS; k++) begin : g_div
        q2aa_div_cell #(.B(QUO_BITS - 1 - k)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (dv_v[k]),
            .i_carry (dv_c[k]),
            .i_dv    (dv_d[k]),
            .o_vld   (dv_v[k+1]),
            .o_carry (dv_c[k+1]),
            .o_dv    (dv_d[k+1])
        );
    end

    // ---- CORDIC setup: saturate the axis, seed x, y, z
    logic    r_v2;
    t_carry  r_c2;
    t_cordic r_k2, n_k2;
    logic [QUO_BITS-1:0]  qs;
    logic signed [CW-1:0] sv, wv;

    always_comb begin
        n_k2 = '0;
        qs   = '0;
        for (int l = 0; l < 3; l++) begin
            qs = dv_d[QUO_BITS].q[l];
            if (dv_d[QUO_BITS].big[l] || qs > QUO_BITS'(ONE_Q)) qs = QUO_BITS'(ONE_Q);
            n_k2.axis[l] = dv_d[QUO_BITS].neg[l] ? 16'(-{1'b0, qs}) : 16'(qs);
        end
        sv = CW'(dv_d[QUO_BITS].s) <<< CSHIFT;
        wv = CW'(dv_c[QUO_BITS].w) <<< CSHIFT;
        if (dv_c[QUO_BITS].w < 0) begin
            n_k2.x = sv;
            n_k2.y = -wv;
            n_k2.z = HALF_PI_Q30;
        end else begin
            n_k2.x = wv;
            n_k2.y = sv;
            n_k2.z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else          r_v2 <= dv_v[QUO_BITS];
        r_c2 <= dv_c[QUO_BITS];
        r_k2 <= n_k2;
    end

    // ---- CORDIC chain
    logic    cr_v [0:CORDIC_STAGES];
    t_carry  cr_c [0:CORDIC_STAGES];
    t_cordic cr_d [0:CORDIC_STAGES];

    assign cr_v[0] = r_v2;
    assign cr_c[0] = r_c2;
    assign cr_d[0] = r_k2;

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
        q2aa_cordic_cell #(.I(k)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (cr_v[k]),
            .i_carry (cr_c[k]),
            .i_cr    (cr_d[k]),
            .o_vld   (cr_v[k+1]),
            .o_carry (cr_c[k+1]),
            .o_cr    (cr_d[k+1])
        );
    end

    // ---- output stage: round the angle, apply the degenerate override
    logic    r_v3;
    t_result r_res, n_res;
    logic signed [CW-1:0] zc;
    logic [CW-1:0]        zr;
    logic [17:0]          ang;

    always_comb begin
        zc  = (cr_d[CORDIC_STAGES].z < 0) ? '0 : cr_d[CORDIC_STAGES].z;
        zr  = CW'(zc) + CW'(32768);
        ang = zr[CW-1:16];
        if (ang > ANGLE_MAX) ang = ANGLE_MAX;
        n_res.axis_x     = cr_d[CORDIC_STAGES].axis[0];
        n_res.axis_y     = cr_d[CORDIC_STAGES].axis[1];
        n_res.axis_z     = cr_d[CORDIC_STAGES].axis[2];
        n_res.rot_angle  = ang[15:0];
        n_res.degenerate = cr_c[CORDIC_STAGES].deg;
        if (cr_c[CORDIC_STAGES].deg) begin
            // zero the axis; w >= 1 gives no rotation, w <= -1 a full turn
            n_res.axis_x    = '0;
            n_res.axis_y    = '0;
            n_res.axis_z    = '0;
            n_res.rot_angle = (cr_c[CORDIC_STAGES].w < 0) ? ANGLE_MAX[15:0] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v3 <= 1'b0;
        else          r_v3 <= cr_v[CORDIC_STAGES];
        r_res <= n_res;
    end

    assign o_done   = r_v3;
    assign o_result = r_res;

    // ---- checks
    a_angle_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_result.rot_angle <= ANGLE_MAX[15:0])
        else $error("rot_angle above two pi");

    a_deg_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.degenerate) |->
            (o_result.axis_x == 0 && o_result.axis_y == 0 && o_result.axis_z == 0))
        else $error("degenerate beat with nonzero axis");

    a_axis_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.axis_x <= $signed(ONE_Q) && o_result.axis_x >= -$signed(ONE_Q)
                 && o_result.axis_y <= $signed(ONE_Q) && o_result.axis_y >= -$signed(ONE_Q)
                 && o_result.axis_z <= $signed(ONE_Q) && o_result.axis_z >= -$signed(ONE_Q)))
        else $error("axis component not saturated");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for quaternion_to_axis_angle
// Drives quaternion beats through the command handshake and checks every
// result beat against a local fixed-point model of the root, divide and
// CORDIC arctangent chain, under several sender idle patterns.
// ----------------------------------------------------------------------------
module testbench;
    import q2aa_pkg::*;

    localparam int NUM_RANDOM  = 1525;
    localparam int LATENCY     = 50;
    localparam int CYCLE_LIMIT = 400000;
    localparam int STAGES      = 16;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start = 1'b0;
    logic    busy;
    t_quat   i_quat = '0;
    logic    o_done;
    t_result o_result;

    t_result axis_angle_q[$];
    int      error_count = 0;
    int      cycle_count = 0;
    int      idle_pct = 0;

    quaternion_to_axis_angle #(.CORDIC_STAGES(STAGES)) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_quat   (i_quat),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always #10 i_clk = ~i_clk;

    // Integer square root by digit recurrence, floor result.
    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // Vector part over s, round half away from zero, saturate to +-1.
    function automatic logic [15:0] axis_component(input longint v, input longint unsigned s);
        longint unsigned mag, q;
        mag = (v < 0) ? -v : v;
        q = ((mag << FRAC_BITS) + s / 2) / s;
        if (q > (64'd1 << FRAC_BITS)) q = 64'd1 << FRAC_BITS;
        return (v < 0) ? 16'(-q) : 16'(q);
    endfunction

    function automatic longint arctan_step(input int i);
        if (i < 10) return longint'(atan_q30(i));
        if (i <= 30) return 64'sd1 <<< (30 - i);
        return 0;
    endfunction

    // 2*acos(w) computed as 2*atan2(s, w) in vectoring mode (Q.30).
    function automatic logic [15:0] rotation_angle(input longint w, input longint unsigned s);
        longint x, y, z, nx;
        longint unsigned a;
        if (w < 0) begin
            x = longint'(s) <<< CSHIFT;
            y = -(w <<< CSHIFT);
            z = 64'sd1686629713;
        end else begin
            x = w <<< CSHIFT;
            y = longint'(s) <<< CSHIFT;
            z = 0;
        end
        for (int i = 0; i < STAGES; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z += arctan_step(i);
            end else begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z -= arctan_step(i);
            end
            x = nx;
        end
        if (z < 0) z = 0;
        a = (longint'(z) + 32768) >> 16;
        if (a > 51472) a = 51472;
        return 16'(a);
    endfunction

    function automatic t_result convert_quat(input t_quat q);
        t_result r;
        longint  w, one;
        longint unsigned s;
        w   = q.quat_w;
        one = 64'sd1 <<< FRAC_BITS;
        r   = '0;
        if (w >= one || w <= -one) begin
            // degenerate scalar: zero axis, angle clamped to 0 or two pi
            r.rot_angle  = (w >= one) ? 16'd0 : 16'(ANGLE_MAX);
            r.degenerate = 1'b1;
            return r;
        end
        s = int_sqrt((64'd1 << (2 * FRAC_BITS)) - longint'(w * w));
        if (s == 0) s = 1;
        r.axis_x    = axis_component(q.quat_x, s);
        r.axis_y    = axis_component(q.quat_y, s);
        r.axis_z    = axis_component(q.quat_z, s);
        r.rot_angle = rotation_angle(w, s);
        return r;
    endfunction

    // Drop start only while idling; hold the beat until it is taken.
    task automatic send_quat(input t_quat q);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_quat <= q;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        axis_angle_q.push_back(convert_quat(q));
    endtask

    function automatic logic [15:0] rand_field();
        case ($urandom_range(9))
            0:       return 16'($urandom);
            1:       return 16'(16384 - $urandom_range(3));
            2:       return 16'(-16384 + $urandom_range(3));
            default: return 16'($urandom_range(32768) - 16384);
        endcase
    endfunction

    // Check each result beat against the oldest prediction.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_done) begin
            if (axis_angle_q.size() == 0) begin
                $error("unexpected result beat");
                error_count = error_count + 1;
            end else begin
                t_result e;
                e = axis_angle_q.pop_front();
                if (o_result.axis_x !== e.axis_x) begin
                    $error("axis_x exp %0d got %0d", e.axis_x, o_result.axis_x);
                    error_count = error_count + 1;
                end
                if (o_result.axis_y !== e.axis_y) begin
                    $error("axis_y exp %0d got %0d", e.axis_y, o_result.axis_y);
                    error_count = error_count + 1;
                end
                if (o_result.axis_z !== e.axis_z) begin
                    $error("axis_z exp %0d got %0d", e.axis_z, o_result.axis_z);
                    error_count = error_count + 1;
                end
                if (o_result.rot_angle !== e.rot_angle) begin
                    $error("rot_angle exp %0d got %0d", e.rot_angle, o_result.rot_angle);
                    error_count = error_count + 1;
                end
                if (o_result.degenerate !== e.degenerate) begin
                    $error("degenerate exp %0b got %0b", e.degenerate, o_result.degenerate);
                    error_count = error_count + 1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** quaternion_to_axis_angle: FAILED **");
            $finish;
        end
    end

    // Field extremes, degenerate scalars, saturating axes and all-bits patterns.
    task automatic test_directed();
        logic signed [15:0] pts[10] = '{16'sd0, 16'sd1, -16'sd1, 16'sd16383, -16'sd16383,
                                        16'sd16384, -16'sd16384, 16'sh7FFF, 16'sh8000, 16'sd11585};
        for (int i = 0; i < 10; i++)
            send_quat('{pts[i], pts[(i+3)%10], pts[(i+6)%10], pts[(i+8)%10]});
        send_quat('{16'sd16383, 16'sd16384, -16'sd16384, 16'sd100});
        send_quat('{-16'sd16383, 16'sh7FFF, 16'sh8000, 16'sd0});
        send_quat('{16'sd0, 16'sd16384, 16'sd0, 16'sd0});
        send_quat('{16'sd8192, 16'sd14189, 16'sd0, 16'sd0});
        send_quat('{-16'sd8192, 16'sd0, -16'sd14189, 16'sd0});
        send_quat('{16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF});
        send_quat('{16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA});
        send_quat('{16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555});
    endtask

    task automatic test_random(input int pct, input int count);
        idle_pct = pct;
        for (int i = 0; i < count; i++)
            send_quat('{rand_field(), rand_field(), rand_field(), rand_field()});
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(0, NUM_RANDOM / 3);
        test_random(60, NUM_RANDOM / 3);
        test_random(30, NUM_RANDOM - 2 * (NUM_RANDOM / 3));
        start <= 1'b0;
        while (axis_angle_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
        if (error_count == 0)
            $display("** quaternion_to_axis_angle: PASSED **");
        else
            $display("** quaternion_to_axis_angle: FAILED **");
        $finish;
    end

endmodule

// ===== sim.f =====
design/q2aa_pkg.sv
design/q2aa_sqrt_cell.sv
design/q2aa_div_cell.sv
design/q2aa_cordic_cell.sv
design/quaternion_to_axis_angle.sv
verif/testbench.sv
